>>> rtl/epoch_barrier_slot_table_unit_defines.svh
// Assertion macros shared by the slot table RTL.
// Each macro takes a label, the checked expression(s) and a message.
`ifndef EPOCH_BARRIER_SLOT_TABLE_UNIT_DEFINES_SVH
`define EPOCH_BARRIER_SLOT_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge out of reset
`define EBST_ASSERT_NOW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Consequent that must hold in the same cycle as the antecedent
`define EBST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Consequent that must hold in the cycle after the antecedent
`define EBST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define EBST_ASSERT_NOW(lbl, cond, msg)
`define EBST_ASSERT_IMP(lbl, ante, cons, msg)
`define EBST_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/ebst_pkg.sv
`default_nettype none

package ebst_pkg;

  // Table geometry
  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_WATCHERS  = 8;
  localparam int EXP_W         = $clog2(MAX_WATCHERS + 1);

  // Field widths
  localparam int WORD_W     = 32;
  localparam int GEN_W      = 16;
  localparam int HS_W       = 4;
  localparam int ACT_W      = 3;
  localparam int ST_W       = 3;
  localparam int MODE_W     = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 120;

  typedef enum logic [ACT_W-1:0] {
    ACT_CREATE    = 3'd0,
    ACT_CLOSE     = 3'd1,
    ACT_ADVANCE   = 3'd2,
    ACT_ARRIVE    = 3'd3,
    ACT_OBSERVE   = 3'd4,
    ACT_RECORD_OP = 3'd5,
    ACT_QUERY     = 3'd6,
    ACT_RESET_ALL = 3'd7
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK            = 3'd0,
    ST_INVALID_ARG   = 3'd1,
    ST_NOT_FOUND     = 3'd2,
    ST_INVALID_STATE = 3'd3,
    ST_EXHAUSTED     = 3'd4
  } status_t;

  // Slot trigger modes; the fourth code counts arrivals but never advances
  localparam logic [MODE_W-1:0] MODE_MANUAL    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BARRIER   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_THRESHOLD = 2'd2;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] phase;
    logic [WORD_W-1:0] arrivals;
    logic [WORD_W-1:0] threshold;
    logic [WORD_W-1:0] limit;
    logic [EXP_W-1:0]  expected;
    logic [GEN_W-1:0]  gen;
    logic [WORD_W-1:0] ops;
  } slot_rec_t;

  // Shared adder and comparator operands and results
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic              inc;
    logic [WORD_W-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] sum;
    logic              lt;
  } alu_rsp_t;

endpackage

`default_nettype wire

>>> rtl/ebst_alu.sv
`default_nettype none

// Shared unit: a + inc, and whether that full-precision sum is below c
module ebst_alu import ebst_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [WORD_W:0] sum_w;

  // Keep the carry so that an all-ones value plus one never compares low
  assign sum_w   = {1'b0, req.a} + {{WORD_W{1'b0}}, req.inc};
  assign rsp.sum = sum_w[WORD_W-1:0];
  assign rsp.lt  = sum_w < {1'b0, req.c};

endmodule

`default_nettype wire

>>> rtl/ebst_slot_mem.sv
`default_nettype none

// Slot record store: one write and one registered read per cycle.
// Entries never written read back as all zero.
module ebst_slot_mem import ebst_pkg::*; #(
  parameter  int DEPTH = NUM_SLOTS_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  slot_rec_t       wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output slot_rec_t       rd_data
);

  slot_rec_t        mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  slot_rec_t        rd_data_r;
  logic             rd_vld_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Track written entries; reset leaves every entry reading as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

>>> rtl/epoch_barrier_slot_table_unit.sv
`default_nettype none
// Channel | dir | tdata (lsb up)                                        | tuser
// in_     | in  | handle_slot 4, handle_gen 16, new_mode 2,            | action 3
//         |     | new_threshold 32, new_phase_limit 32, zero pad 2      |
// out_    | out | out_slot 4, out_gen 16, is_active 1, phase_now 32,    | status 3
//         |     | arrivals_now 32, ops_used 32, advanced 1, zero pad 2  |
// cfg_    | in  | cfg_wr_data = op_budget 32, written when cfg_wr_en    | -
//
// After accept a request runs load, execute, write-back and finish; out_tvalid rises
// from finish. A stale handle skips execute; query, close or an action refused by its
// state check skip write-back; observe, record_op and arrive repeat execute.
// Create scans up to slots_in_use + 1 slots before its load; reset_all sweeps every slot.
// Reset clears the table at once through per-entry valid bits; no clearing pass.
// One request in work at a time; a result waiting on out_tready holds the sequencer.
`include "epoch_barrier_slot_table_unit_defines.svh"

module epoch_barrier_slot_table_unit import ebst_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // handle_slot, handle_gen, new_mode, new_threshold, new_phase_limit
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_slot, out_gen, is_active, phase_now, arrivals_now, ops_used, advanced
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [ST_W-1:0]       out_tuser,
  input  logic                  cfg_wr_en,
  input  logic [WORD_W-1:0]     cfg_wr_data
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W  = (CNT_W > HS_W) ? CNT_W : HS_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_EX    = 7'b0001000,
    S_WB    = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  action_t              act_r, act_nxt;
  logic [HS_W-1:0]      hs_r, hs_nxt;
  logic [GEN_W-1:0]     hg_r, hg_nxt;
  logic [MODE_W-1:0]    mode_r, mode_nxt;
  logic [WORD_W-1:0]    thr_r, thr_nxt;
  logic [WORD_W-1:0]    lim_r, lim_nxt;
  logic [CNT_W-1:0]     ptr_r, ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  slot_rec_t            rec_r, rec_nxt;
  status_t              st_r, st_nxt;
  logic                 adv_r, adv_nxt;
  logic                 rep_r, rep_nxt;
  logic [1:0]           step_r, step_nxt;
  logic [WORD_W-1:0]    budget_r, budget_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]      out_st_r, out_st_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                 in_fire;
  action_t              in_act;
  logic [SLOT_W-1:0]    idx;
  logic                 cur_active;
  logic                 hs_ok;
  logic                 may_adv;
  logic                 arr_ge;
  logic                 trig;
  logic                 echo;
  logic                 sweep_last;
  logic [CNT_W-1:0]     ptr_inc;
  logic [GEN_W-1:0]     gen_inc;
  logic [GEN_W-1:0]     gen_bump;
  logic [HS_W-1:0]      res_slot;
  logic [GEN_W-1:0]     res_gen;
  logic                 res_active;

  logic                 mem_wr_en;
  slot_rec_t            mem_wr_data;
  logic                 mem_rd_en;
  logic [SLOT_W-1:0]    mem_rd_addr;
  slot_rec_t            mem_rd;

  alu_req_t             alu_req;
  alu_rsp_t             alu_rsp;

  ebst_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ebst_slot_mem #(
    .DEPTH (NUM_SLOTS)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (idx),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd)
  );

  // Handshake and decoded helpers
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_act     = action_t'(in_tuser);
  assign idx        = ptr_r[SLOT_W-1:0];
  assign cur_active = active_r[idx];
  assign ptr_inc    = ptr_r + CNT_W'(1);
  assign sweep_last = (state_r == S_SWEEP) && (ptr_r == CNT_W'(NUM_SLOTS - 1));
  assign hs_ok      = (CMP_W'(hs_r) < CMP_W'(cnt_r)) && (mem_rd.gen == hg_r);
  assign may_adv    = (rec_r.limit == '0) || alu_rsp.lt;
  assign arr_ge     = !alu_rsp.lt;
  assign trig       = ((rec_r.mode == MODE_BARRIER) && (rec_r.expected != '0) && arr_ge) ||
                      ((rec_r.mode == MODE_THRESHOLD) && arr_ge);
  assign gen_inc    = alu_rsp.sum[GEN_W-1:0];
  assign gen_bump   = (gen_inc == '0) ? GEN_W'(1) : gen_inc;

  // Result fields
  assign echo       = (act_r != ACT_CREATE) && (act_r != ACT_RESET_ALL);
  assign res_slot   = echo ? hs_r  : (rep_r ? HS_W'(ptr_r) : '0);
  assign res_gen    = echo ? hg_r  : (rep_r ? rec_r.gen    : '0);
  assign res_active = rep_r && cur_active;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    hs_nxt        = hs_r;
    hg_nxt        = hg_r;
    mode_nxt      = mode_r;
    thr_nxt       = thr_r;
    lim_nxt       = lim_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    active_nxt    = active_r;
    rec_nxt       = rec_r;
    st_nxt        = st_r;
    adv_nxt       = adv_r;
    rep_nxt       = rep_r;
    step_nxt      = step_r;
    out_st_nxt    = out_st_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    budget_nxt    = cfg_wr_en ? cfg_wr_data : budget_r;
    mem_wr_en     = 1'b0;
    mem_wr_data   = rec_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = idx;
    alu_req       = '0;

    unique case (state_r)
      // Take a request and start the read or the scan
      S_IDLE: begin
        if (in_fire) begin
          act_nxt  = in_act;
          hs_nxt   = in_tdata[3:0];
          hg_nxt   = in_tdata[19:4];
          mode_nxt = in_tdata[21:20];
          thr_nxt  = in_tdata[53:22];
          lim_nxt  = in_tdata[85:54];
          st_nxt   = ST_OK;
          adv_nxt  = 1'b0;
          rep_nxt  = 1'b1;
          step_nxt = 2'd0;
          unique case (in_act) inside
            ACT_CREATE: begin
              ptr_nxt   = '0;
              state_nxt = S_SCAN;
            end
            ACT_RESET_ALL: begin
              ptr_nxt     = '0;
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              state_nxt   = S_SWEEP;
            end
            default: begin
              ptr_nxt     = CNT_W'(in_tdata[3:0]);
              mem_rd_en   = 1'b1;
              mem_rd_addr = SLOT_W'(in_tdata[3:0]);
              state_nxt   = S_LOAD;
            end
          endcase
        end
      end

      // Look for the lowest closed slot in use, else append one, or report exhausted when full
      S_SCAN: begin
        if (ptr_r < cnt_r) begin
          if (!cur_active) begin
            mem_rd_en = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            ptr_nxt = ptr_inc;
          end
        end else if (cnt_r == CNT_W'(NUM_SLOTS)) begin
          st_nxt    = ST_EXHAUSTED;
          rep_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = cnt_r[SLOT_W-1:0];
          ptr_nxt     = cnt_r;
          cnt_nxt     = cnt_r + CNT_W'(1);
          state_nxt   = S_LOAD;
        end
      end

      // Capture the entry and check the handle
      S_LOAD: begin
        rec_nxt = mem_rd;
        if ((act_r != ACT_CREATE) && !hs_ok) begin
          st_nxt    = (act_r == ACT_RECORD_OP) ? ST_INVALID_ARG : ST_NOT_FOUND;
          rep_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_EX;
        end
      end

      // One pass of the shared unit per cycle
      S_EX: begin
        unique case (act_r) inside
          ACT_CREATE: begin
            alu_req.a         = WORD_W'(rec_r.gen);
            alu_req.inc       = 1'b1;
            rec_nxt.gen       = gen_bump;
            rec_nxt.mode      = mode_r;
            rec_nxt.threshold = thr_r;
            rec_nxt.limit     = lim_r;
            rec_nxt.phase     = '0;
            rec_nxt.arrivals  = '0;
            rec_nxt.expected  = '0;
            active_nxt[idx]   = 1'b1;
            state_nxt         = S_WB;
          end
          ACT_CLOSE: begin
            active_nxt[idx] = 1'b0;
            state_nxt       = S_FIN;
          end
          ACT_ADVANCE: begin
            alu_req.a   = rec_r.phase;
            alu_req.inc = 1'b1;
            alu_req.c   = rec_r.limit;
            if (!cur_active || (rec_r.mode != MODE_MANUAL)) begin
              st_nxt    = ST_INVALID_STATE;
              state_nxt = S_FIN;
            end else if (may_adv) begin
              rec_nxt.phase    = alu_rsp.sum;
              rec_nxt.arrivals = '0;
              adv_nxt          = 1'b1;
              state_nxt        = S_WB;
            end else begin
              st_nxt    = ST_EXHAUSTED;
              state_nxt = S_FIN;
            end
          end
          ACT_ARRIVE: begin
            case (step_r)
              2'd0: begin
                alu_req.a   = rec_r.arrivals;
                alu_req.inc = 1'b1;
                if (!cur_active || (rec_r.mode == MODE_MANUAL)) begin
                  st_nxt    = ST_INVALID_STATE;
                  state_nxt = S_FIN;
                end else begin
                  rec_nxt.arrivals = alu_rsp.sum;
                  step_nxt         = 2'd1;
                end
              end
              2'd1: begin
                alu_req.a = rec_r.arrivals;
                alu_req.c = (rec_r.mode == MODE_BARRIER) ? WORD_W'(rec_r.expected)
                                                         : rec_r.threshold;
                if (trig) begin
                  step_nxt = 2'd2;
                end else begin
                  state_nxt = S_WB;
                end
              end
              2'd2: begin
                alu_req.a   = rec_r.phase;
                alu_req.inc = 1'b1;
                alu_req.c   = rec_r.limit;
                if (may_adv) begin
                  rec_nxt.phase    = alu_rsp.sum;
                  rec_nxt.arrivals = '0;
                  adv_nxt          = 1'b1;
                end
                state_nxt = S_WB;
              end
              default: begin
                state_nxt = S_WB;
              end
            endcase
          end
          ACT_OBSERVE: begin
            alu_req.a = WORD_W'(rec_r.expected);
            if (step_r == 2'd0) begin
              alu_req.c = WORD_W'(MAX_WATCHERS);
              if (!alu_rsp.lt) begin
                st_nxt    = ST_EXHAUSTED;
                state_nxt = S_FIN;
              end else begin
                step_nxt = 2'd1;
              end
            end else begin
              alu_req.inc      = 1'b1;
              rec_nxt.expected = alu_rsp.sum[EXP_W-1:0];
              state_nxt        = S_WB;
            end
          end
          ACT_RECORD_OP: begin
            alu_req.a = rec_r.ops;
            if (step_r == 2'd0) begin
              alu_req.inc = 1'b1;
              if (!cur_active) begin
                st_nxt    = ST_INVALID_STATE;
                state_nxt = S_FIN;
              end else begin
                rec_nxt.ops = alu_rsp.sum;
                step_nxt    = 2'd1;
              end
            end else begin
              alu_req.c = budget_r;
              if ((budget_r != '0) && !alu_rsp.lt) begin
                st_nxt = ST_EXHAUSTED;
              end
              state_nxt = S_WB;
            end
          end
          ACT_QUERY, ACT_RESET_ALL: begin
            state_nxt = S_FIN;
          end
        endcase
      end

      // Write the updated entry back
      S_WB: begin
        mem_wr_en = 1'b1;
        state_nxt = S_FIN;
      end

      // Bump every generation, one entry per cycle, read ahead by one
      S_SWEEP: begin
        alu_req.a       = WORD_W'(mem_rd.gen);
        alu_req.inc     = 1'b1;
        mem_wr_data     = mem_rd;
        mem_wr_data.gen = gen_bump;
        mem_wr_en       = 1'b1;
        if (sweep_last) begin
          active_nxt = '0;
          cnt_nxt    = '0;
          rep_nxt    = 1'b0;
          state_nxt  = S_FIN;
        end else begin
          ptr_nxt     = ptr_inc;
          mem_rd_en   = 1'b1;
          mem_rd_addr = ptr_inc[SLOT_W-1:0];
        end
      end

      // Load the output register once it is free
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = st_r;
          if (rep_r) begin
            out_data_nxt = {2'b00, adv_r, rec_r.ops, rec_r.arrivals, rec_r.phase,
                            res_active, res_gen, res_slot};
          end else begin
            out_data_nxt = {{(OUT_DATA_W - GEN_W - HS_W){1'b0}}, res_gen, res_slot};
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      active_r    <= '0;
      budget_r    <= '0;
      out_valid_r <= 1'b0;
      step_r      <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      active_r    <= active_nxt;
      budget_r    <= budget_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Request and working payload
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    hs_r       <= hs_nxt;
    hg_r       <= hg_nxt;
    mode_r     <= mode_nxt;
    thr_r      <= thr_nxt;
    lim_r      <= lim_nxt;
    ptr_r      <= ptr_nxt;
    rec_r      <= rec_nxt;
    st_r       <= st_nxt;
    adv_r      <= adv_nxt;
    rep_r      <= rep_nxt;
    out_st_r   <= out_st_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_st_r;

  `EBST_ASSERT_NOW(a_cnt_bound, cnt_r <= CNT_W'(NUM_SLOTS), "slots in use beyond table size")
  `EBST_ASSERT_NOW(a_active_in_use, (active_r >> cnt_r) == '0, "active slot above slots in use")
  `EBST_ASSERT_NXT(a_sweep_clears, sweep_last, (cnt_r == '0) && (active_r == '0), "sweep left slots")
  `EBST_ASSERT_IMP(a_out_from_fin, $rose(out_valid_r), $past(state_r == S_FIN), "stray result")

endmodule

`default_nettype wire

>>> tb/epoch_barrier_slot_table_unit_tb.sv
`timescale 1ns / 1ps

import ebst_pkg::*;

// One result as it should leave the block
typedef struct {
  status_t     st;
  bit [3:0]    slot;
  bit [15:0]   gen;
  bit          act;
  bit [31:0]   phase;
  bit [31:0]   arrivals;
  bit [31:0]   ops;
  bit          adv;
} slot_result_t;

class slot_table_scoreboard;
  bit [31:0]   budget;
  bit          active [16];
  bit [1:0]    mode [16];
  bit [31:0]   phase [16];
  bit [31:0]   arrivals [16];
  bit [31:0]   thresh [16];
  bit [31:0]   limit [16];
  bit [3:0]    watchers [16];
  bit [15:0]   gen [16];
  bit [31:0]   ops [16];
  int unsigned in_use;
  int          errors;
  slot_result_t awaited_results[$];

  function int pending();
    return awaited_results.size();
  endfunction

  function bit [15:0] bump_gen(bit [15:0] g);
    return (g == 16'hFFFF) ? 16'd1 : g + 16'd1;
  endfunction

  // Allow a step only below a nonzero phase limit; compare at 33 bits
  function bit may_advance(int i);
    return limit[i] == 32'd0 || ({1'b0, phase[i]} + 33'd1) < {1'b0, limit[i]};
  endfunction

  function void step_phase(int i);
    phase[i]    = phase[i] + 32'd1;
    arrivals[i] = 32'd0;
    active[i]   = 1'b1;
  endfunction

  // Queue a result; without slot data every field but slot and generation is zero
  function void push_result(status_t st, int s, bit [15:0] g, bit with_slot, bit adv);
    slot_result_t r;
    r.st       = st;
    r.slot     = s[3:0];
    r.gen      = g;
    r.act      = with_slot ? active[s] : 1'b0;
    r.phase    = with_slot ? phase[s] : 32'd0;
    r.arrivals = with_slot ? arrivals[s] : 32'd0;
    r.ops      = with_slot ? ops[s] : 32'd0;
    r.adv      = with_slot ? adv : 1'b0;
    awaited_results.push_back(r);
  endfunction

  // Apply one accepted request to the table and queue what it returns
  function void note_request(action_t a, bit [3:0] hs, bit [15:0] hg, bit [1:0] m,
                             bit [31:0] t, bit [31:0] l);
    int      idx;
    status_t st;
    bit      adv;
    st  = ST_OK;
    adv = 1'b0;
    if (a == ACT_CREATE) begin
      idx = -1;
      for (int i = 0; i < in_use; i++) begin
        if (!active[i]) begin
          idx = i;
          break;
        end
      end
      if (idx < 0) begin
        if (in_use >= 16) begin
          push_result(ST_EXHAUSTED, 0, 16'd0, 1'b0, 1'b0);
          return;
        end
        idx = in_use;
        in_use++;
      end
      gen[idx]      = bump_gen(gen[idx]);
      mode[idx]     = m;
      thresh[idx]   = t;
      limit[idx]    = l;
      active[idx]   = 1'b1;
      phase[idx]    = 32'd0;
      arrivals[idx] = 32'd0;
      watchers[idx] = 4'd0;
      push_result(ST_OK, idx, gen[idx], 1'b1, 1'b0);
      return;
    end
    if (a == ACT_RESET_ALL) begin
      for (int i = 0; i < 16; i++) begin
        active[i] = 1'b0;
        gen[i]    = bump_gen(gen[i]);
      end
      in_use = 0;
      push_result(ST_OK, 0, 16'd0, 1'b0, 1'b0);
      return;
    end
    // Stale or out-of-range handle: echo it back
    if (hs >= in_use || gen[hs] != hg) begin
      push_result((a == ACT_RECORD_OP) ? ST_INVALID_ARG : ST_NOT_FOUND, hs, hg, 1'b0, 1'b0);
      return;
    end
    case (a)
      ACT_CLOSE: begin
        active[hs] = 1'b0;
      end
      ACT_ADVANCE: begin
        if (!active[hs] || mode[hs] != MODE_MANUAL) st = ST_INVALID_STATE;
        else if (!may_advance(hs)) st = ST_EXHAUSTED;
        else begin
          step_phase(hs);
          adv = 1'b1;
        end
      end
      ACT_ARRIVE: begin
        if (!active[hs] || mode[hs] == MODE_MANUAL) st = ST_INVALID_STATE;
        else begin
          arrivals[hs] = arrivals[hs] + 32'd1;
          if (mode[hs] == MODE_BARRIER) begin
            if (watchers[hs] != 4'd0 && arrivals[hs] >= watchers[hs] && may_advance(hs)) begin
              step_phase(hs);
              adv = 1'b1;
            end
          end else if (mode[hs] == MODE_THRESHOLD) begin
            if (arrivals[hs] >= thresh[hs] && may_advance(hs)) begin
              step_phase(hs);
              adv = 1'b1;
            end
          end
        end
      end
      ACT_OBSERVE: begin
        if (watchers[hs] >= MAX_WATCHERS) st = ST_EXHAUSTED;
        else watchers[hs] = watchers[hs] + 4'd1;
      end
      ACT_RECORD_OP: begin
        if (!active[hs]) st = ST_INVALID_STATE;
        else begin
          ops[hs] = ops[hs] + 32'd1;
          if (budget != 32'd0 && ops[hs] >= budget) st = ST_EXHAUSTED;
        end
      end
      default: ;
    endcase
    push_result(st, hs, hg, 1'b1, adv);
  endfunction

  function void cmp(string field, logic [31:0] e, logic [31:0] got);
    if (got !== e) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, e, got);
    end
  endfunction

  // Compare one accepted result with the oldest one awaited
  function void check_result(logic [119:0] d, logic [2:0] u);
    slot_result_t r;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual tdata 0x%0h tuser 0x%0h",
               $time, d, u);
      return;
    end
    r = awaited_results.pop_front();
    cmp("status", r.st, u);
    cmp("out_slot", r.slot, d[3:0]);
    cmp("out_gen", r.gen, d[19:4]);
    cmp("is_active", r.act, d[20]);
    cmp("phase_now", r.phase, d[52:21]);
    cmp("arrivals_now", r.arrivals, d[84:53]);
    cmp("ops_used", r.ops, d[116:85]);
    cmp("advanced", r.adv, d[117]);
    cmp("pad", 32'd0, d[119:118]);
  endfunction

  function void close_out();
    if (awaited_results.size() != 0) begin
      errors += awaited_results.size();
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
    end
  endfunction
endclass

module epoch_barrier_slot_table_unit_tb;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // handle_slot, handle_gen, new_mode, new_threshold, new_phase_limit
  logic [87:0]  in_tdata = '0;
  // action
  logic [2:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // out_slot, out_gen, is_active, phase_now, arrivals_now, ops_used, advanced
  logic [119:0] out_tdata;
  // status
  logic [2:0]   out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [31:0]  cfg_wr_data = '0;

  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  slot_table_scoreboard sb = new;

  epoch_barrier_slot_table_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Offer one request, idling first at random; keep valid high afterwards
  task automatic send(action_t a, bit [3:0] s, bit [15:0] g, bit [1:0] m = 2'd0,
                      bit [31:0] t = 32'd0, bit [31:0] l = 32'd0);
    while (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, l, t, m, g, s};
    in_tuser  <= a;
    do begin
      @(posedge clk);
    end while (!in_tready);
    sb.note_request(a, s, g, m, t, l);
  endtask

  // Build a random request, mostly on live handles
  task automatic send_random(int create_pct);
    action_t   a;
    bit [3:0]  s;
    bit [15:0] g;
    bit [1:0]  m;
    bit [31:0] t;
    bit [31:0] l;
    int        r;
    r = $urandom_range(99);
    if (r < create_pct) a = ACT_CREATE;
    else begin
      r = $urandom_range(99);
      if (r < 10)      a = ACT_CLOSE;
      else if (r < 30) a = ACT_ADVANCE;
      else if (r < 58) a = ACT_ARRIVE;
      else if (r < 70) a = ACT_OBSERVE;
      else if (r < 84) a = ACT_RECORD_OP;
      else if (r < 98) a = ACT_QUERY;
      else             a = ACT_RESET_ALL;
    end
    if (sb.in_use > 0 && $urandom_range(99) < 85) begin
      s = 4'($urandom_range(sb.in_use - 1));
      g = sb.gen[s];
    end else begin
      s = 4'($urandom);
      case ($urandom_range(2))
        0:       g = 16'($urandom);
        1:       g = sb.gen[s] - 16'd1;
        default: g = sb.gen[s];
      endcase
    end
    m = 2'($urandom);
    t = $urandom;
    l = $urandom;
    if (a == ACT_CREATE) begin
      m = ($urandom_range(99) < 8) ? 2'd3 : 2'($urandom_range(2));
      case ($urandom_range(9))
        0:       t = $urandom;
        1:       t = 32'hFFFF_FFFF;
        default: t = $urandom_range(4);
      endcase
      r = $urandom_range(9);
      if (r < 4)       l = 32'd0;
      else if (r < 8)  l = $urandom_range(6, 1);
      else if (r == 8) l = $urandom;
      else             l = 32'hFFFF_FFFF;
    end
    send(a, s, g, m, t, l);
  endtask

  // Wait until every awaited result is in, then let the block settle
  task automatic wait_drained(int settle);
    int n;
    n = 0;
    while (sb.pending() > 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (settle) @(posedge clk);
  endtask

  // Write the op budget once the block is idle
  task automatic write_budget(bit [31:0] v);
    in_tvalid <= 1'b0;
    wait_drained(24);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.budget = v;
  endtask

  // Result side: random back-pressure, with one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_tready <= calm || $urandom_range(99) >= 23;
      end
    end
  end

  // Check every accepted result
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  initial begin
    bit [31:0] budgets [6];
    int        create_mix [6];
    budgets    = '{32'd0, 32'd1, 32'd3 + $urandom_range(12), 32'hFFFF_FFFF, $urandom, 32'd0};
    create_mix = '{15, 15, 55, 12, 20, 15};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_budget(32'd2);

    // Empty table, bad handles
    send(ACT_QUERY, 4'd0, 16'd0);
    send(ACT_RECORD_OP, 4'd15, 16'hFFFF);
    // Manual slot and a hand advance
    send(ACT_CREATE, 4'd0, 16'd0, MODE_MANUAL);
    send(ACT_ADVANCE, 4'd0, 16'd1);
    // Barrier: no observers holds the phase, two observers release it
    send(ACT_CREATE, 4'd0, 16'd0, MODE_BARRIER);
    send(ACT_ARRIVE, 4'd1, 16'd1);
    send(ACT_OBSERVE, 4'd1, 16'd1);
    send(ACT_OBSERVE, 4'd1, 16'd1);
    send(ACT_ARRIVE, 4'd1, 16'd1);
    // Threshold of zero with limit two: advance once, then skip silently
    send(ACT_CREATE, 4'd0, 16'd0, MODE_THRESHOLD, 32'd0, 32'd2);
    send(ACT_ARRIVE, 4'd2, 16'd1);
    send(ACT_ARRIVE, 4'd2, 16'd1);
    // Undefined mode counts arrivals but refuses a hand advance
    send(ACT_CREATE, 4'd0, 16'd0, 2'd3, 32'hFFFF_FFFF, 32'd1);
    send(ACT_ADVANCE, 4'd3, 16'd1);
    send(ACT_ARRIVE, 4'd3, 16'd1);
    // Hand advance past the limit
    send(ACT_CREATE, 4'd0, 16'd0, MODE_MANUAL, 32'd0, 32'd1);
    send(ACT_ADVANCE, 4'd4, 16'd1);
    // Budget of two: the second op is exhausted
    send(ACT_RECORD_OP, 4'd0, 16'd1);
    send(ACT_RECORD_OP, 4'd0, 16'd1);
    // Closed slot: close, advance, arrive, observe, close again
    send(ACT_CLOSE, 4'd0, 16'd1);
    send(ACT_ADVANCE, 4'd0, 16'd1);
    send(ACT_ARRIVE, 4'd0, 16'd1);
    send(ACT_OBSERVE, 4'd0, 16'd1);
    send(ACT_CLOSE, 4'd0, 16'd1);
    // Reuse of the closed slot keeps its op count
    send(ACT_CREATE, 4'd0, 16'd0, MODE_MANUAL, 32'd0, 32'hFFFF_FFFF);
    send(ACT_ARRIVE, 4'd0, 16'd2);
    // Reset all invalidates old handles
    send(ACT_RESET_ALL, 4'd0, 16'd0);
    send(ACT_QUERY, 4'd1, 16'd1);

    // Random phases, each under its own budget
    for (int p = 0; p < 6; p++) begin
      write_budget(budgets[p]);
      calm = (p == 4);
      if (p == 2) hold_off_req = 1'b1;
      repeat (240) send_random(create_mix[p]);
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
    wait_drained(30);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard limit on the run
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ebst_pkg.sv
rtl/ebst_alu.sv
rtl/ebst_slot_mem.sv
rtl/epoch_barrier_slot_table_unit.sv
tb/epoch_barrier_slot_table_unit_tb.sv
